/* rtl/core/dcsr_pkg.sv */
// ----------------------------------------------------------------------------
// dcsr_pkg
// Shared types and constants of the daisy-chain slave relay.
// ----------------------------------------------------------------------------
`default_nettype none

package dcsr_pkg;

  // packet parse phases
  localparam logic [2:0] PH_ID     = 3'd0;
  localparam logic [2:0] PH_COUNT  = 3'd1;
  localparam logic [2:0] PH_SCAN   = 3'd2;
  localparam logic [2:0] PH_OPCODE = 3'd3;
  localparam logic [2:0] PH_LENGTH = 3'd4;
  localparam logic [2:0] PH_OWN    = 3'd5;
  localparam logic [2:0] PH_OTHER  = 3'd6;
  localparam logic [2:0] PH_CHECK  = 3'd7;

  // length nibble escape: the length follows in the next byte
  localparam logic [3:0] LEN_ESC = 4'hF;

  // command nibbles that dump the stored payload at packet end
  localparam logic [3:0] OP_OUT0 = 4'h2;
  localparam logic [3:0] OP_OUT1 = 4'h3;
  localparam logic [3:0] OP_OUT2 = 4'h6;
  localparam logic [3:0] OP_OUT3 = 4'h7;
  localparam logic [3:0] OP_OUT4 = 4'h8;
  localparam logic [3:0] OP_OUT5 = 4'h9;

  // configuration register index (paddr[2])
  localparam logic REG_BOARD_TYPE = 1'b0;
  localparam logic [7:0] BOARD_TYPE_RST = 8'h01;

  typedef struct packed {
    logic       take;        // input transfer this cycle
    logic [2:0] phase;       // phase the byte is parsed in
    logic       load_relay;  // relay result straight to the output register
    logic       hold_relay;  // park relay result, start a burst
    logic       rd;          // read payload store at burst index
    logic       load_cmd;    // command result to the output register
    logic       send_relay;  // parked relay result to the output register
  } dcsr_cmd_t;

  typedef struct packed {
    logic nib_esc;
    logic nib_zero;
    logic byte_zero;
    logic own_msg;
    logic pos_hit;
    logic scan_hit;
    logic last_msg;
    logic burst_go;
    logic burst_end;
    logic out_free;
  } dcsr_sts_t;

  typedef struct packed {
    logic       is_relay;
    logic [7:0] tx_byte;
    logic [3:0] cmd_opcode;
    logic [7:0] cmd_length;
    logic [5:0] cmd_index;
    logic [7:0] cmd_data;
    logic       overflow;
    logic       last;
  } dcsr_res_t;

  function automatic logic is_out_op(input logic [3:0] op);
    return (op == OP_OUT0) || (op == OP_OUT1) || (op == OP_OUT2) ||
           (op == OP_OUT3) || (op == OP_OUT4) || (op == OP_OUT5);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/dcsr_if.sv */
// ----------------------------------------------------------------------------
// dcsr_in_if / dcsr_out_if
// Valid/ready channels of the relay: received bytes in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcsr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [7:0] or_bits;

  modport source (output valid, output rx_byte, output or_bits, input ready);
  modport sink   (input valid, input rx_byte, input or_bits, output ready);
endinterface

interface dcsr_out_if;
  logic       valid;
  logic       ready;
  logic       is_relay;
  logic [7:0] tx_byte;
  logic [3:0] cmd_opcode;
  logic [7:0] cmd_length;
  logic [5:0] cmd_index;
  logic [7:0] cmd_data;
  logic       overflow;
  logic       last;

  modport source (output valid, output is_relay, output tx_byte, output cmd_opcode,
                  output cmd_length, output cmd_index, output cmd_data,
                  output overflow, output last, input ready);
  modport sink   (input valid, input is_relay, input tx_byte, input cmd_opcode,
                  input cmd_length, input cmd_index, input cmd_data,
                  input overflow, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/daisy_chain_slave_relay_unit.sv */
// ----------------------------------------------------------------------------
// daisy_chain_slave_relay_unit
// Slave node of a daisy-chained byte bus: relays each byte, patches the ID
// and scan bytes, captures its own payload and dumps it at packet end.
// ----------------------------------------------------------------------------
//   channel  dir  handshake        carries
//   rx_i     in   valid/ready      rx_byte, or_bits
//   tx_o     out  valid/ready      is_relay, tx_byte, cmd_* fields, overflow, last
//   apb      in   psel/penable     board_type register at paddr 0
//
// A byte is taken every cycle while the result register drains each cycle.
// A final checksum that dumps stored bytes holds off rx_i through the whole burst:
// every burst result waits on the payload store's registered read port.
// rst_ni clears the parser and sequencer; the payload store needs no clearing.
// A stall on tx_o stalls rx_i once the result register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module daisy_chain_slave_relay_unit #(
  parameter int PAYLOAD_DEPTH = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  dcsr_in_if.sink     rx_i,
  dcsr_out_if.source  tx_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dcsr_pkg::*;

  dcsr_cmd_t  cmd;
  dcsr_sts_t  sts;
  dcsr_res_t  res;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] board_type_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_type_q <= BOARD_TYPE_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_BOARD_TYPE)) begin
      board_type_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_BOARD_TYPE) ? {24'h0, board_type_q} : 32'h0;

  dcsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dcsr_dpath #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_i.rx_byte),
    .or_bits_i    (rx_i.or_bits),
    .board_type_i (board_type_q),
    .out_ready_i  (tx_o.ready),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid),
    .res_o        (res)
  );

  assign rx_i.ready      = in_ready;
  assign tx_o.valid      = out_valid;
  assign tx_o.is_relay   = res.is_relay;
  assign tx_o.tx_byte    = res.tx_byte;
  assign tx_o.cmd_opcode = res.cmd_opcode;
  assign tx_o.cmd_length = res.cmd_length;
  assign tx_o.cmd_index  = res.cmd_index;
  assign tx_o.cmd_data   = res.cmd_data;
  assign tx_o.overflow   = res.overflow;
  assign tx_o.last       = res.last;

endmodule

`default_nettype wire

/* rtl/core/dcsr_ctrl.sv */
// ----------------------------------------------------------------------------
// dcsr_ctrl
// Packet parse state machine and result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsr_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  dcsr_pkg::dcsr_sts_t  sts_i,
  output dcsr_pkg::dcsr_cmd_t  cmd_o
);
  import dcsr_pkg::*;

  localparam logic [1:0] SQ_IDLE  = 2'd0;
  localparam logic [1:0] SQ_READ  = 2'd1;
  localparam logic [1:0] SQ_LOAD  = 2'd2;
  localparam logic [1:0] SQ_RELAY = 2'd3;

  logic [2:0] phase_q, phase_d;
  logic [1:0] seq_q, seq_d;
  logic       take;
  logic       burst;

  assign in_ready_o = (seq_q == SQ_IDLE) && sts_i.out_free;
  assign take       = in_valid_i && in_ready_o;
  assign burst      = (phase_q == PH_CHECK) && sts_i.last_msg && sts_i.burst_go;

  always_comb begin
    phase_d = phase_q;
    if (take) begin
      unique case (phase_q) inside
        PH_ID:     phase_d = PH_COUNT;
        PH_COUNT:  phase_d = sts_i.byte_zero ? PH_SCAN : PH_OPCODE;
        PH_SCAN:   phase_d = sts_i.scan_hit ? PH_ID : PH_SCAN;
        PH_OPCODE: begin
          if (sts_i.nib_esc)       phase_d = PH_LENGTH;
          else if (sts_i.nib_zero) phase_d = PH_CHECK;
          else                     phase_d = sts_i.own_msg ? PH_OWN : PH_OTHER;
        end
        PH_LENGTH: begin
          if (sts_i.byte_zero) phase_d = PH_CHECK;
          else                 phase_d = sts_i.own_msg ? PH_OWN : PH_OTHER;
        end
        PH_OWN, PH_OTHER: phase_d = sts_i.pos_hit ? PH_CHECK : phase_q;
        PH_CHECK:  phase_d = sts_i.last_msg ? PH_ID : PH_OPCODE;
        default:   phase_d = PH_ID;
      endcase
    end
  end

  always_comb begin
    seq_d = seq_q;
    cmd_o = '0;
    cmd_o.take  = take;
    cmd_o.phase = phase_q;
    unique case (seq_q)
      SQ_IDLE: begin
        if (take) begin
          if (burst) begin
            cmd_o.hold_relay = 1'b1;
            seq_d            = SQ_READ;
          end else begin
            cmd_o.load_relay = 1'b1;
          end
        end
      end
      SQ_READ: begin
        cmd_o.rd = 1'b1;
        seq_d    = SQ_LOAD;
      end
      SQ_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_cmd = 1'b1;
          seq_d          = sts_i.burst_end ? SQ_RELAY : SQ_READ;
        end
      end
      SQ_RELAY: begin
        if (sts_i.out_free) begin
          cmd_o.send_relay = 1'b1;
          seq_d            = SQ_IDLE;
        end
      end
      default: seq_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID;
      seq_q   <= SQ_IDLE;
    end else begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dcsr_dpath.sv */
// ----------------------------------------------------------------------------
// dcsr_dpath
// Packet counters, own-message capture, payload store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsr_dpath #(
  parameter int PAYLOAD_DEPTH = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire [7:0]            rx_byte_i,
  input  wire [7:0]            or_bits_i,
  input  wire [7:0]            board_type_i,
  input  wire                  out_ready_i,
  input  dcsr_pkg::dcsr_cmd_t  cmd_i,
  output dcsr_pkg::dcsr_sts_t  sts_o,
  output logic                 out_valid_o,
  output dcsr_pkg::dcsr_res_t  res_o
);
  import dcsr_pkg::*;

  localparam int         IW     = $clog2(PAYLOAD_DEPTH);
  localparam logic [7:0] DEPTH8 = 8'(PAYLOAD_DEPTH);

  logic [7:0] node_id_q, msg_total_q, msg_num_q, pos_q, cur_len_q, own_len_q;
  logic [3:0] own_op_q;
  logic       own_seen_q;
  logic [7:0] relay_q;
  logic [IW-1:0] idx_q;
  logic [7:0] rd_data_q;
  logic       out_valid_q;
  dcsr_res_t  res_q;

  logic [7:0] store_q [PAYLOAD_DEPTH];

  logic [7:0] pos_inc;
  logic [7:0] relay_byte;
  logic [7:0] burst_len;
  logic [7:0] idx_inc;
  logic       store_wr;
  logic       load_any;

  assign pos_inc   = pos_q + 8'd1;
  assign burst_len = (own_len_q > DEPTH8) ? DEPTH8 : own_len_q;
  assign idx_inc   = 8'(idx_q) + 8'd1;
  assign store_wr  = cmd_i.take && (cmd_i.phase == PH_OWN) && (pos_q < DEPTH8);
  assign load_any  = cmd_i.load_relay || cmd_i.load_cmd || cmd_i.send_relay;

  always_comb begin
    relay_byte = rx_byte_i;
    case (cmd_i.phase)
      PH_ID:   relay_byte = rx_byte_i + 8'd1;
      PH_SCAN: if (sts_o.scan_hit) relay_byte = board_type_i;
      PH_OWN:  relay_byte = rx_byte_i | or_bits_i;
      default: relay_byte = rx_byte_i;
    endcase
  end

  always_comb begin
    sts_o.nib_esc   = rx_byte_i[3:0] == LEN_ESC;
    sts_o.nib_zero  = rx_byte_i[3:0] == 4'h0;
    sts_o.byte_zero = rx_byte_i == 8'h00;
    sts_o.own_msg   = msg_num_q == node_id_q;
    sts_o.pos_hit   = pos_inc == cur_len_q;
    sts_o.scan_hit  = pos_inc == node_id_q;
    sts_o.last_msg  = msg_num_q == msg_total_q;
    sts_o.burst_go  = own_seen_q && is_out_op(own_op_q) && (own_len_q != 8'h00);
    sts_o.burst_end = idx_inc == burst_len;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // packet bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q   <= '0;
      msg_total_q <= '0;
      msg_num_q   <= '0;
      pos_q       <= '0;
      cur_len_q   <= '0;
      own_op_q    <= '0;
      own_len_q   <= '0;
      own_seen_q  <= 1'b0;
    end else if (cmd_i.take) begin
      case (cmd_i.phase)
        PH_ID: begin
          node_id_q  <= rx_byte_i;
          pos_q      <= '0;
          msg_num_q  <= 8'd1;
          own_seen_q <= 1'b0;
        end
        PH_COUNT: begin
          msg_total_q <= rx_byte_i;
          pos_q       <= '0;
        end
        PH_OPCODE: begin
          pos_q     <= '0;
          cur_len_q <= {4'h0, rx_byte_i[3:0]};
          if (sts_o.own_msg) begin
            own_op_q   <= rx_byte_i[7:4];
            own_seen_q <= 1'b1;
            if (!sts_o.nib_esc) own_len_q <= {4'h0, rx_byte_i[3:0]};
          end
        end
        PH_LENGTH: begin
          cur_len_q <= rx_byte_i;
          if (sts_o.own_msg) own_len_q <= rx_byte_i;
        end
        PH_CHECK: begin
          if (sts_o.last_msg) own_seen_q <= 1'b0;
          msg_num_q <= msg_num_q + 8'd1;
        end
        default: pos_q <= pos_inc;  // scan, own and other payload bytes
      endcase
    end
  end

  // payload store, registered read
  always_ff @(posedge clk_i) begin
    if (store_wr) store_q[pos_q[IW-1:0]] <= relay_byte;
    if (cmd_i.rd) rd_data_q <= store_q[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_relay) relay_q <= relay_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.hold_relay) begin
      idx_q <= '0;
    end else if (cmd_i.load_cmd) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_any) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cmd) begin
      res_q.is_relay   <= 1'b0;
      res_q.tx_byte    <= 8'h00;
      res_q.cmd_opcode <= own_op_q;
      res_q.cmd_length <= own_len_q;
      res_q.cmd_index  <= 6'(idx_q);
      res_q.cmd_data   <= rd_data_q;
      res_q.overflow   <= own_len_q > DEPTH8;
      res_q.last       <= 1'b0;
    end else if (cmd_i.load_relay || cmd_i.send_relay) begin
      res_q.is_relay   <= 1'b1;
      res_q.tx_byte    <= cmd_i.send_relay ? relay_q : relay_byte;
      res_q.cmd_opcode <= 4'h0;
      res_q.cmd_length <= 8'h00;
      res_q.cmd_index  <= 6'h00;
      res_q.cmd_data   <= 8'h00;
      res_q.overflow   <= 1'b0;
      res_q.last       <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* rtl/core/dcsr_checker.sv */
// ----------------------------------------------------------------------------
// dcsr_checker
// Port-level checks of the relay unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsr_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       is_relay,
  input wire [7:0] tx_byte,
  input wire [3:0] cmd_opcode,
  input wire [7:0] cmd_length,
  input wire [5:0] cmd_index,
  input wire [7:0] cmd_data,
  input wire       overflow,
  input wire       last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last) &&
                                $stable(cmd_data) && $stable(cmd_index))
    else $error("result changed while stalled");

  // the relay result is always the closing one
  a_relay_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (is_relay == last))
    else $error("relay result and last flag disagree");

  a_relay_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && is_relay |-> (cmd_opcode == 4'h0) && (cmd_length == 8'h00) &&
                              (cmd_index == 6'h00) && (cmd_data == 8'h00) && !overflow)
    else $error("relay result carries command fields");

  a_cmd_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !is_relay |-> (tx_byte == 8'h00))
    else $error("command result carries a tx byte");

  // no new byte while a burst is still going out
  a_burst_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !last |-> !in_ready)
    else $error("input taken during a burst");

endmodule

bind daisy_chain_slave_relay_unit dcsr_checker u_dcsr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (rx_i.ready),
  .out_valid  (tx_o.valid),
  .out_ready  (tx_o.ready),
  .is_relay   (tx_o.is_relay),
  .tx_byte    (tx_o.tx_byte),
  .cmd_opcode (tx_o.cmd_opcode),
  .cmd_length (tx_o.cmd_length),
  .cmd_index  (tx_o.cmd_index),
  .cmd_data   (tx_o.cmd_data),
  .overflow   (tx_o.overflow),
  .last       (tx_o.last)
);

`default_nettype wire
